// ===== design/sbh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbh_pkg
// Shared types, constants and SHA-256 functions for the byte stream hasher.
// ----------------------------------------------------------------------------
package sbh_pkg;

  // One input word: a message byte with its flags.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } sbh_item_t;

  // One output word: the finished digest.
  typedef struct packed {
    logic [31:0] hash_word_0;
    logic [31:0] hash_word_1;
    logic [31:0] hash_word_2;
    logic [31:0] hash_word_3;
    logic [31:0] hash_word_4;
    logic [31:0] hash_word_5;
    logic [31:0] hash_word_6;
    logic [31:0] hash_word_7;
  } sbh_digest_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_ADD,
    S_PAD,
    S_OUT
  } sbh_state_t;

  // Control from the sequencer to the schedule and round units.
  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       init;
    logic       calc;
    logic       step;
    logic [5:0] round;
    logic       finish;
    logic       restart;
  } sbh_ctrl_t;

  localparam int unsigned LEN_FIELD_BITS = 64;
  localparam logic [7:0]  PAD_MARK       = 8'h80;
  localparam logic [5:0]  LEN_OFFSET     = 6'd56;
  localparam logic [5:0]  FILL_LAST      = 6'd63;
  localparam logic [5:0]  ROUND_LAST     = 6'd63;

  // Initial hash values; entry 0 is the first word.
  localparam logic [7:0][31:0] H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  // Round constants.
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428a2f98;
      6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;
      6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;
      6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;
      6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;
      6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;
      6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;
      6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;
      6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;
      6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;
      6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;
      6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;
      6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;
      6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;
      6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;
      6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;
      6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;
      6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;
      6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;
      6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;
      6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;
      6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;
      6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;
      6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;
      6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;
      6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;
      6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;
      6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;
      6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;
      6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;
      6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;
      6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;
      6'd63: round_k = 32'hc67178f2;
      default: round_k = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== design/sha256_byte_stream_hasher.sv =====
// Message bytes are taken one per cycle while the sequencer is idle, not while a block
// is compressed or padded or a digest waits to load. Each full 64-byte block runs 64
// rounds on the one shared round unit, each in two halves, then an add into the
// chaining value. A closing word costs 9 to 72 padding bytes at one per cycle, one or two
// block compressions, then the digest word is loaded once the last one is taken.
// The digest word waits in its own register; synchronous reset empties it and the block.
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream: byte packing, padding and length sequencer
// around a shared round unit.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher #(
  parameter int unsigned LENGTH_COUNTER_BITS = 64
) (
  input  wire                  logic clk,
  input  wire                  logic rst,
  input  wire                  logic item_valid,
  output                       logic item_ready,
  input  wire sbh_pkg::sbh_item_t    item,
  output                       logic digest_valid,
  input  wire                  logic digest_ready,
  output      sbh_pkg::sbh_digest_t  digest
);

  sbh_pkg::sbh_state_t              state;
  sbh_pkg::sbh_state_t              state_next;
  sbh_pkg::sbh_ctrl_t               ctrl;
  sbh_pkg::sbh_digest_t             chain_word;
  logic [5:0]                       fill;
  logic [LENGTH_COUNTER_BITS-1:0]   count;
  logic [5:0]                       round;
  logic                             phase;
  logic                             closing;
  logic                             sent80;
  logic                             tail;
  logic                             final_blk;
  logic                             accept_in;
  logic                             accept_out;
  logic                             out_load;
  logic                             wrap;
  logic [sbh_pkg::LEN_FIELD_BITS-1:0] bit_len;
  logic [5:0]                       len_base;
  logic [7:0]                       len_byte;
  logic [7:0]                       pad_byte;
  logic [31:0]                      w_word;

  assign accept_in  = item_valid && item_ready;
  assign accept_out = digest_valid && digest_ready;
  assign out_load   = (state == sbh_pkg::S_OUT) && (!digest_valid || digest_ready);
  assign wrap       = (fill == sbh_pkg::FILL_LAST);

  // Padding byte: the marker, then zeros, then the bit length big-endian.
  always_comb begin
    bit_len  = sbh_pkg::LEN_FIELD_BITS'(count) << 3;
    len_base = {~fill[2:0], 3'b000};
    len_byte = bit_len[len_base +: 8];
    if (!sent80) begin
      pad_byte = sbh_pkg::PAD_MARK;
    end else if (tail && (fill >= sbh_pkg::LEN_OFFSET)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = '0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sbh_pkg::S_IDLE: begin
        if (accept_in) begin
          if (item.byte_present && wrap) begin
            state_next = sbh_pkg::S_ROUND;
          end else if (item.last) begin
            state_next = sbh_pkg::S_PAD;
          end
        end
      end
      sbh_pkg::S_ROUND: begin
        if (phase && (round == sbh_pkg::ROUND_LAST)) begin
          state_next = sbh_pkg::S_ADD;
        end
      end
      sbh_pkg::S_ADD: begin
        if (final_blk) begin
          state_next = sbh_pkg::S_OUT;
        end else if (closing) begin
          state_next = sbh_pkg::S_PAD;
        end else begin
          state_next = sbh_pkg::S_IDLE;
        end
      end
      sbh_pkg::S_PAD: begin
        if (wrap) begin
          state_next = sbh_pkg::S_ROUND;
        end
      end
      sbh_pkg::S_OUT: begin
        if (out_load) begin
          state_next = sbh_pkg::S_IDLE;
        end
      end
      default: state_next = sbh_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    item_ready     = (state == sbh_pkg::S_IDLE);
    ctrl.push      = ((state == sbh_pkg::S_IDLE) && item_valid && item.byte_present)
                   || (state == sbh_pkg::S_PAD);
    ctrl.push_byte = (state == sbh_pkg::S_IDLE) ? item.data_byte : pad_byte;
    ctrl.init      = ctrl.push && wrap;
    ctrl.calc      = (state == sbh_pkg::S_ROUND) && !phase;
    ctrl.step      = (state == sbh_pkg::S_ROUND) && phase;
    ctrl.round     = round;
    ctrl.finish    = (state == sbh_pkg::S_ADD);
    ctrl.restart   = out_load;
  end

  // Sequencer registers, counters and padding flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sbh_pkg::S_IDLE;
      fill         <= '0;
      count        <= '0;
      round        <= '0;
      phase        <= 1'b0;
      closing      <= 1'b0;
      sent80       <= 1'b0;
      tail         <= 1'b0;
      final_blk    <= 1'b0;
      digest_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.push) begin
        fill <= fill + 6'd1;
      end
      if (accept_in && item.byte_present) begin
        count <= count + LENGTH_COUNTER_BITS'(1);
      end
      if (ctrl.init) begin
        round <= '0;
        phase <= 1'b0;
      end else if (state == sbh_pkg::S_ROUND) begin
        phase <= ~phase;
        if (phase) begin
          round <= round + 6'd1;
        end
      end
      if (accept_in && item.last) begin
        closing <= 1'b1;
      end
      // The length goes in this block only if the marker landed before it;
      // a marker in the last byte of a block pushes the length to the next.
      if (state == sbh_pkg::S_PAD) begin
        if (!sent80) begin
          sent80 <= 1'b1;
          tail   <= (fill < sbh_pkg::LEN_OFFSET) || wrap;
        end else if (wrap) begin
          if (tail) begin
            final_blk <= 1'b1;
          end else begin
            tail <= 1'b1;
          end
        end
      end
      if (out_load) begin
        count     <= '0;
        closing   <= 1'b0;
        sent80    <= 1'b0;
        tail      <= 1'b0;
        final_blk <= 1'b0;
      end
      // The digest word stays offered until it is taken.
      if (out_load) begin
        digest_valid <= 1'b1;
      end else if (accept_out) begin
        digest_valid <= 1'b0;
      end
    end
  end

  // Output register for the digest word.
  always_ff @(posedge clk) begin
    if (out_load) begin
      digest <= chain_word;
    end
  end

  sbh_sched u_sched (
    .clk    (clk),
    .ctrl   (ctrl),
    .w_word (w_word)
  );

  sbh_round u_round (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .w_word (w_word),
    .digest (chain_word)
  );

`ifndef ASSERT_OFF
  // A digest is only loaded once the final block has been fully consumed.
  assert property (@(posedge clk) disable iff (rst)
    (state == sbh_pkg::S_OUT) |-> (fill == '0))
    else $error("digest loaded with a part-filled block");

  // The last round hands over to the chaining value update.
  assert property (@(posedge clk) disable iff (rst)
    ((state == sbh_pkg::S_ROUND) && phase && (round == sbh_pkg::ROUND_LAST))
      |=> (state == sbh_pkg::S_ADD))
    else $error("compression did not end after the last round");

  // A closing word always makes the block busy.
  assert property (@(posedge clk) disable iff (rst)
    (accept_in && item.last) |=> !item_ready)
    else $error("closing word did not start padding");

  // The update of the final block is followed by the digest hand-off.
  assert property (@(posedge clk) disable iff (rst)
    ((state == sbh_pkg::S_ADD) && final_blk) |=> (state == sbh_pkg::S_OUT))
    else $error("final block finished without a digest");

  // Loading the digest clears the length for the next message.
  assert property (@(posedge clk) disable iff (rst)
    out_load |=> ((state == sbh_pkg::S_IDLE) && (count == '0) && digest_valid))
    else $error("state not restored after digest");

  // A waiting digest word is held unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (digest_valid && !digest_ready) |=> (digest_valid && $stable(digest)))
    else $error("digest word changed while waiting");
`endif

endmodule
`default_nettype wire

// ===== design/sbh_sched.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbh_sched
// Block buffer and message schedule. Bytes shift in at the bottom of a
// 512-bit line; during the rounds the same line acts as the sixteen-word
// schedule window, oldest word at the top.
// ----------------------------------------------------------------------------
module sbh_sched (
  input  wire                logic        clk,
  input  wire sbh_pkg::sbh_ctrl_t         ctrl,
  output      logic [31:0]                w_word
);

  logic [511:0] block;
  logic [31:0]  w_new;

  // Next schedule word from the fixed taps of the window.
  always_comb begin
    w_new = block[511:480] + sbh_pkg::small_sigma0(block[479:448])
          + block[223:192] + sbh_pkg::small_sigma1(block[63:32]);
  end

  // Byte loading and word shifting share the one line.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      block <= {block[503:0], ctrl.push_byte};
    end else if (ctrl.step) begin
      block <= {block[479:0], w_new};
    end
  end

  assign w_word = block[511:480];

endmodule
`default_nettype wire

// ===== design/sbh_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbh_round
// Shared round unit: working variables, one round in two halves, and the
// chaining value that collects each block's result.
// ----------------------------------------------------------------------------
module sbh_round (
  input  wire                 logic        clk,
  input  wire                 logic        rst,
  input  wire sbh_pkg::sbh_ctrl_t          ctrl,
  input  wire                 logic [31:0] w_word,
  output      sbh_pkg::sbh_digest_t        digest
);

  logic [7:0][31:0] chain;
  logic [7:0][31:0] wv;
  logic [31:0]      t1;
  logic [31:0]      t2;
  logic [31:0]      t1_next;
  logic [31:0]      t2_next;

  // First half of a round: the two temporary sums.
  always_comb begin
    t1_next = wv[7] + sbh_pkg::big_sigma1(wv[4])
            + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
            + sbh_pkg::round_k(ctrl.round) + w_word;
    t2_next = sbh_pkg::big_sigma0(wv[0])
            + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  always_ff @(posedge clk) begin
    if (ctrl.calc) begin
      t1 <= t1_next;
      t2 <= t2_next;
    end
  end

  // Second half of a round: rotate the working variables.
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      wv <= chain;
    end else if (ctrl.step) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

  // Chaining value: initial values after reset and after each digest.
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      chain <= sbh_pkg::H_INIT;
    end else if (ctrl.finish) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= chain[i] + wv[i];
      end
    end
  end

  assign digest.hash_word_0 = chain[0];
  assign digest.hash_word_1 = chain[1];
  assign digest.hash_word_2 = chain[2];
  assign digest.hash_word_3 = chain[3];
  assign digest.hash_word_4 = chain[4];
  assign digest.hash_word_5 = chain[5];
  assign digest.hash_word_6 = chain[6];
  assign digest.hash_word_7 = chain[7];

endmodule
`default_nettype wire
